@@ hdl/crc16_sector_bit_repair_core_defines.svh @@
// Assertion macros shared by the CRC-16 sector repair RTL.
// Depends on nothing; each user supplies clk and rst_n in its own scope.
`ifndef CRC16_SECTOR_BIT_REPAIR_CORE_DEFINES_SVH
`define CRC16_SECTOR_BIT_REPAIR_CORE_DEFINES_SVH

// Condition that must hold on every clock outside reset.
`define CSBR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define CSBR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/csbr_pkg.sv @@
// Package for the CRC-16 sector repair block: beat types, codes, CRC helpers.
// Depends on nothing.
`default_nettype none
package csbr_pkg;

  localparam int MAX_SECTOR_BYTES_DEF = 1024;
  localparam int MAX_WEAK_BITS_DEF    = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  // x^16 mod P: change from flipping bit 0 of the final byte
  localparam logic [15:0] SYN_LAST = 16'h1021;

  localparam logic [1:0] STATUS_MATCH = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_OVER  = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  weak_byte;
    logic [15:0] crc_expect;
    logic        last_byte;
  } csbr_in_t;

  typedef struct packed {
    logic [1:0]  repair_status;
    logic [12:0] bit_position;
    logic [15:0] flip_combination;
  } csbr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINV,
    ST_SFWD,
    ST_WREAD,
    ST_WBITS,
    ST_WSRCH
  } csbr_state_t;

  // Multiply by x modulo the CRC polynomial (one shift of the CRC register).
  function automatic logic [15:0] mul_x(input logic [15:0] v);
    mul_x = {v[14:0], 1'b0} ^ (v[15] ? CRC_POLY : 16'h0000);
  endfunction

  // Eight register shifts: multiply by x^8.
  function automatic logic [15:0] clock8(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    for (int k = 0; k < 8; k++) r = mul_x(r);
    clock8 = r;
  endfunction

  // Inverse of clock8: divide by x^8. Bit 0 after a shift holds the old MSB.
  function automatic logic [15:0] unclock8(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = ((r ^ CRC_POLY) >> 1) | 16'h8000;
      else r = r >> 1;
    end
    unclock8 = r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/crc16_sector_bit_repair_core.sv @@
// CRC-16/CCITT-FALSE sector repair: loads a sector, then searches for a bit fix.
// Depends on csbr_pkg and crc16_sector_bit_repair_core_defines.svh.
//
// Usage: drive in_beat and raise start; a beat is taken at each clock where
// start is high and busy is low. Bytes load one per cycle while busy stays low;
// the CRC is folded in as they arrive. The beat with last_byte set ends the
// sector and starts the search; busy then stays high until the result strobe.
// One result beat per sector appears on out_beat with out_valid high for one
// cycle, in the same cycle busy drops. The receiver cannot stall it.
// Search after the last byte, n = stored bytes:
//   single-bit mode: the syndrome target is rotated back by x^8 per cycle,
//     n times, then walked forward per byte until a match or the last byte.
//   weak-bit mode: walks the weak mask memory backward one bit per cycle,
//     with a read state before each byte, then tries each weak-bit
//     combination in turn (up to 2^16).
// cfg_we/cfg_wdata set the search mode; write it only while idle.
// Synchronous reset clears the byte count, CRC, mode and state; the weak mask
// memory needs no clearing since only bytes of the current sector are read.
`default_nettype none
`include "crc16_sector_bit_repair_core_defines.svh"
module crc16_sector_bit_repair_core #(
  parameter int MAX_SECTOR_BYTES = csbr_pkg::MAX_SECTOR_BYTES_DEF,
  parameter int MAX_WEAK_BITS    = csbr_pkg::MAX_WEAK_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire csbr_pkg::csbr_in_t in_beat,
  output logic                    out_valid,
  output csbr_pkg::csbr_out_t     out_beat,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata
);
  import csbr_pkg::*;

  localparam int CNT_W = $clog2(MAX_SECTOR_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_SECTOR_BYTES);
  localparam int WC_W  = $clog2(MAX_WEAK_BITS + 2);
  localparam int CB_W  = MAX_WEAK_BITS + 1;

  csbr_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      tgt_r, tgt_nxt;
  logic [15:0]      t_r, t_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [WC_W-1:0]  wcnt_r, wcnt_nxt;
  logic [15:0]      wsyn_r [MAX_WEAK_BITS];
  logic [15:0]      wsyn_nxt [MAX_WEAK_BITS];
  logic [CB_W-1:0]  combo_r, combo_nxt;
  logic             mode_r;
  logic             out_valid_r, out_valid_nxt;
  csbr_out_t        out_r, out_nxt;

  logic [7:0]       weak_mem [MAX_SECTOR_BYTES];
  logic [7:0]       rd_data_r;
  logic             accept, store;
  logic [15:0]      crc_new, comb_syn;
  logic [CNT_W-1:0] n_new;
  logic [2:0]       hot_bit;
  logic             hot_hit;
  logic [IDX_W+2:0] pos_full;

  assign accept = start && (state_r == ST_IDLE);
  assign store  = accept && (cnt_r < CNT_W'(MAX_SECTOR_BYTES));
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // Weak mask memory: write while loading, registered read at addr_r
  always_ff @(posedge clk) begin
    if (store) weak_mem[cnt_r[IDX_W-1:0]] <= in_beat.weak_byte;
    rd_data_r <= weak_mem[addr_r];
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    idx_r   <= idx_nxt;
    tgt_r   <= tgt_nxt;
    t_r     <= t_nxt;
    addr_r  <= addr_nxt;
    bit_r   <= bit_nxt;
    wcnt_r  <= wcnt_nxt;
    combo_r <= combo_nxt;
    out_r   <= out_nxt;
    for (int k = 0; k < MAX_WEAK_BITS; k++) wsyn_r[k] <= wsyn_nxt[k];
  end

  // Helpers: running CRC, one-hot match of t_r, weak-combination syndrome
  always_comb begin
    crc_new = clock8(crc_r ^ {in_beat.data_byte, 8'h00});
    n_new   = store ? cnt_r + CNT_W'(1) : cnt_r;
    hot_bit = 3'd0;
    for (int k = 0; k < 8; k++) if (t_r[8+k]) hot_bit = 3'(k);
    hot_hit = (t_r[7:0] == 8'h00) && (t_r[15:8] != 8'h00)
              && ((t_r[15:8] & (t_r[15:8] - 8'h01)) == 8'h00);
    pos_full = {idx_r[IDX_W-1:0], 3'(3'd7 - hot_bit)};
    comb_syn = 16'h0000;
    for (int k = 0; k < MAX_WEAK_BITS; k++) if (combo_r[k]) comb_syn ^= wsyn_r[k];
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    t_nxt         = t_r;
    addr_nxt      = addr_r;
    bit_nxt       = bit_r;
    wcnt_nxt      = wcnt_r;
    combo_nxt     = combo_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    for (int k = 0; k < MAX_WEAK_BITS; k++) wsyn_nxt[k] = wsyn_r[k];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (store) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            crc_nxt = crc_new;
          end
          if (in_beat.last_byte) begin
            tgt_nxt  = (store ? crc_new : crc_r) ^ in_beat.crc_expect;
            n_nxt    = n_new;
            cnt_nxt  = '0;
            crc_nxt  = CRC_INIT;
            t_nxt    = (store ? crc_new : crc_r) ^ in_beat.crc_expect;
            idx_nxt  = n_new;
            t_nxt    = (store ? crc_new : crc_r) ^ in_beat.crc_expect;
            addr_nxt = IDX_W'(n_new - CNT_W'(1));
            bit_nxt  = 3'd0;
            wcnt_nxt = '0;
            combo_nxt = '0;
            idx_nxt  = mode_r ? idx_r : n_new;
            t_nxt    = mode_r ? SYN_LAST : t_nxt;
            state_nxt = mode_r ? ST_WREAD : ST_SINV;
          end
        end
      end
      // Rotate the target back by x^8 once per stored byte
      ST_SINV: begin
        if (idx_r == '0) begin
          state_nxt = ST_SFWD;
        end else begin
          t_nxt   = unclock8(t_r);
          idx_nxt = idx_r - CNT_W'(1);
        end
      end
      // Walk bytes forward; a one-hot high byte over a zero low byte is a single-bit fix
      ST_SFWD: begin
        if (hot_hit) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{repair_status: STATUS_MATCH, bit_position: 13'(pos_full),
                      flip_combination: 16'h0000};
          state_nxt = ST_IDLE;
        end else if (idx_r == n_r - CNT_W'(1)) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{repair_status: STATUS_NONE, bit_position: 13'h0000,
                      flip_combination: 16'h0000};
          state_nxt = ST_IDLE;
        end else begin
          t_nxt   = clock8(t_r);
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_WREAD: begin
        state_nxt = ST_WBITS;
      end
      // Backward over the sector, bit 0 up to bit 7; t_r holds the syndrome
      ST_WBITS: begin
        if (rd_data_r[bit_r]) begin
          if (wcnt_r != WC_W'(MAX_WEAK_BITS + 1)) wcnt_nxt = wcnt_r + WC_W'(1);
          for (int k = MAX_WEAK_BITS - 1; k > 0; k--) wsyn_nxt[k] = wsyn_r[k-1];
          wsyn_nxt[0] = t_r;
        end
        t_nxt   = mul_x(t_r);
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          if (addr_r == '0) begin
            if (wcnt_nxt > WC_W'(MAX_WEAK_BITS)) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{repair_status: STATUS_OVER, bit_position: 13'h0000,
                          flip_combination: 16'h0000};
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_WSRCH;
            end
          end else begin
            addr_nxt  = addr_r - IDX_W'(1);
            state_nxt = ST_WREAD;
          end
        end
      end
      // One combination per cycle, ascending
      ST_WSRCH: begin
        if (comb_syn == tgt_r) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{repair_status: STATUS_MATCH, bit_position: 13'h0000,
                      flip_combination: 16'(combo_r)};
          state_nxt = ST_IDLE;
        end else if (combo_r == (CB_W'(1) << wcnt_r) - CB_W'(1)) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{repair_status: STATUS_NONE, bit_position: 13'h0000,
                      flip_combination: 16'h0000};
          state_nxt = ST_IDLE;
        end else begin
          combo_nxt = combo_r + CB_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Checks
  `CSBR_ASSERT_IMPLY(a_result_after_search, out_valid, $past(busy), "result without search")
  `CSBR_ASSERT_IMPLY(a_fields_clear, out_valid && (out_beat.repair_status != STATUS_MATCH), (out_beat.bit_position == 13'h0000) && (out_beat.flip_combination == 16'h0000), "fields set without match")
  `CSBR_ASSERT_ALWAYS(a_count_bound, cnt_r <= CNT_W'(MAX_SECTOR_BYTES), "byte count overflow")
  `CSBR_ASSERT_IMPLY(a_weak_bound, state_r == ST_WSRCH, wcnt_r <= WC_W'(MAX_WEAK_BITS), "combination search with too many weak bits")

endmodule
`default_nettype wire

@@ tb/crc16_sector_bit_repair_core_tb.sv @@
// Testbench for crc16_sector_bit_repair_core: loads sectors, predicts the repair result.
// Depends on csbr_pkg and the core; self-checking, no external files.
`timescale 1ns / 100ps
`default_nettype none
module crc16_sector_bit_repair_core_tb;
  import csbr_pkg::*;

  localparam int SECTOR_MAX = 1024;
  localparam int WEAK_MAX   = 16;
  localparam int CYCLE_LIMIT = 40000000;

  logic clk, rst_n, start, cfg_we, cfg_wdata;
  logic busy, out_valid;
  csbr_in_t in_beat;
  csbr_out_t out_beat;

  crc16_sector_bit_repair_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [7:0] sec_bytes [SECTOR_MAX];
  logic [7:0] sec_weak [SECTOR_MAX];
  int unsigned sec_len = 0;
  logic repair_mode;
  logic [15:0] bit_syn [SECTOR_MAX*8];

  csbr_in_t  pending_beats[$];
  csbr_out_t repair_expect[$];
  int mismatches = 0;
  int cycles = 0;
  int items_done = 0;
  logic driver_idle;

  function automatic logic [15:0] shift8(input logic [15:0] r);
    for (int k = 0; k < 8; k++) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    return r;
  endfunction

  // Fold one accepted beat into the sector; a last byte yields the repair result.
  task automatic predict_repair(input csbr_in_t b);
    logic [15:0] crc, tgt, s, cur [8];
    logic [15:0] wsyn [WEAK_MAX];
    int unsigned n, cnt;
    bit found;
    csbr_out_t r;
    if (sec_len < SECTOR_MAX) begin
      sec_bytes[sec_len] = b.data_byte;
      sec_weak[sec_len] = b.weak_byte;
      sec_len++;
    end
    if (!b.last_byte) return;
    n = sec_len;
    sec_len = 0;
    for (int k = 0; k < 8; k++) cur[k] = shift8(16'(1 << (k + 8)));
    for (int i = n - 1; i >= 0; i--)
      for (int k = 0; k < 8; k++) begin
        bit_syn[i*8+k] = cur[k];
        cur[k] = shift8(cur[k]);
      end
    crc = 16'hFFFF;
    for (int i = 0; i < n; i++) crc = shift8(crc ^ {sec_bytes[i], 8'h00});
    tgt = crc ^ b.crc_expect;
    r = '0;
    r.repair_status = STATUS_NONE;
    found = 0;
    if (!repair_mode) begin
      for (int i = 0; i < n && !found; i++)
        for (int k = 0; k < 8 && !found; k++)
          if (bit_syn[i*8+k] == tgt) begin
            r.repair_status = STATUS_MATCH;
            r.bit_position = 13'(i*8 + 7 - k);
            found = 1;
          end
    end else begin
      cnt = 0;
      for (int i = 0; i < n; i++)
        for (int k = 7; k >= 0; k--)
          if (sec_weak[i][k]) begin
            if (cnt < WEAK_MAX) wsyn[cnt] = bit_syn[i*8+k];
            cnt++;
          end
      if (cnt > WEAK_MAX) r.repair_status = STATUS_OVER;
      else
        for (int c = 0; c < (1 << cnt) && !found; c++) begin
          s = 0;
          for (int k = 0; k < cnt; k++) if (c[k]) s ^= wsyn[k];
          if (s == tgt) begin
            r.repair_status = STATUS_MATCH;
            r.flip_combination = 16'(c);
            found = 1;
          end
        end
    end
    repair_expect.push_back(r);
  endtask

  // Clock and cycle limit
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: random gaps, beats taken when start && !busy
  int gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_beat <= '0;
      gap <= 0;
    end else if (start && !busy) begin
      predict_repair(in_beat);
      items_done <= items_done + 1;
      if (pending_beats.size() != 0 && $urandom_range(0, 3) != 0) begin
        in_beat <= pending_beats.pop_front();
      end else begin
        start <= 0;
        gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      end
    end else if (!start) begin
      if (gap > 0) gap <= gap - 1;
      else if (pending_beats.size() != 0 && !driver_idle) begin
        in_beat <= pending_beats.pop_front();
        start <= 1;
      end
    end
  end

  // Monitor: every strobe checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (repair_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", out_beat);
      end else begin
        csbr_out_t e;
        e = repair_expect.pop_front();
        if (e !== out_beat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: status %0d/%0d pos %0d/%0d combo %h/%h (exp/got)",
                     e.repair_status, out_beat.repair_status, e.bit_position,
                     out_beat.bit_position, e.flip_combination, out_beat.flip_combination);
        end
      end
    end
  end

  // Builds one sector; flips up to flips bits and marks them weak, plus weak_extra random weak bits
  task automatic queue_sector(input int len, input int flips, input int weak_extra,
                              input bit good_crc);
    logic [7:0] d [], w [];
    logic [15:0] crc;
    csbr_in_t b;
    int p;
    d = new[len];
    w = new[len];
    for (int i = 0; i < len; i++) begin
      d[i] = 8'($urandom);
      w[i] = 8'h00;
    end
    crc = 16'hFFFF;
    for (int i = 0; i < len; i++) crc = shift8(crc ^ {d[i], 8'h00});
    if (!good_crc) crc = 16'($urandom);
    for (int f = 0; f < flips; f++) begin
      p = $urandom_range(0, len*8 - 1);
      d[p/8][p%8] = ~d[p/8][p%8];
      w[p/8][p%8] = 1;
    end
    for (int f = 0; f < weak_extra; f++) begin
      p = $urandom_range(0, len*8 - 1);
      w[p/8][p%8] = 1;
    end
    for (int i = 0; i < len; i++) begin
      b.data_byte = d[i];
      b.weak_byte = w[i];
      b.crc_expect = (i == len - 1) ? crc : 16'($urandom);
      b.last_byte = (i == len - 1);
      pending_beats.push_back(b);
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || start || repair_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= m;
    repair_mode = m;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  csbr_in_t db;
  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    repair_mode = 0;
    driver_idle = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed, single-bit mode: extremes, one-byte sector, clean and fixable
    db = '{8'hFF, 8'hFF, 16'hFFFF, 1'b1};
    pending_beats.push_back(db);
    db = '{8'h00, 8'h00, 16'h0000, 1'b1};
    pending_beats.push_back(db);
    queue_sector(4, 1, 0, 1);
    queue_sector(3, 0, 0, 1);
    queue_sector(5, 2, 0, 1);
    driver_idle = 0;
    wait_drained();

    // Directed, weak-bit mode: clean, too many weak bits, exactly sixteen
    set_mode(1);
    queue_sector(3, 0, 0, 1);
    db = '{8'hA5, 8'hFF, 16'h1234, 1'b0};
    pending_beats.push_back(db);
    pending_beats.push_back(db);
    db.last_byte = 1;
    pending_beats.push_back(db);
    db = '{8'h5A, 8'hFF, 16'h0000, 1'b0};
    pending_beats.push_back(db);
    db = '{8'h3C, 8'hFF, 16'h4321, 1'b1};
    pending_beats.push_back(db);
    queue_sector(4, 2, 3, 1);
    wait_drained();

    // Random sectors in four phases, alternating single-bit and weak-bit mode
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0]);
      while (items_done < 60 + ph * 140) begin
        if (pending_beats.size() < 20)
          queue_sector($urandom_range(1, 12), $urandom_range(0, 2),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4),
                       $urandom_range(0, 4) != 0);
        @(posedge clk);
      end
      wait_drained();
    end

    if (mismatches == 0 && repair_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/csbr_pkg.sv
hdl/crc16_sector_bit_repair_core.sv
tb/crc16_sector_bit_repair_core_tb.sv
